FILE: design/nsr_pkg.sv
// shared constants, state encoding and controller/datapath interface types
package nsr_pkg;

	localparam int MAX_ITER   = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int WIDE_W     = 2 * DATA_W;
	localparam int ITER_W     = $clog2(MAX_ITER + 1);
	localparam int OUT_ITER_W = 6;
	localparam int DVS_W      = DATA_W + 1;
	localparam int DIV_STEPS  = DATA_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int M_TDATA_W  = ((DATA_W + OUT_ITER_W + 7) / 8) * 8;
	localparam int S_TDATA_W  = ((DATA_W + 7) / 8) * 8;
	localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(6554);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_GAP,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic gap;
		logic div_init;
		logic div_step;
		logic update;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic conv_hit;
		logic stop;
		logic div_last;
	} status_t;

endpackage

FILE: design/nsr_ctrl.sv
// sequencer for the newton square root: iteration control and output beat handshake
module nsr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  nsr_pkg::status_t status,
	output nsr_pkg::cmd_t    cmd
);
	import nsr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: state_d = ST_GAP;
			ST_GAP:    state_d = ST_CHECK;
			ST_CHECK: begin
				if (status.conv_hit || status.stop) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_SQUARE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_SQUARE: cmd.square = 1'b1;
			ST_GAP:    cmd.gap    = 1'b1;
			ST_CHECK:  cmd.div_init = !status.conv_hit && !status.stop;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_UPDATE: cmd.update   = 1'b1;
			ST_DONE:   cmd.emit     = out_free;
			default: begin
				cmd      = '0;
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

FILE: design/nsr_dp.sv
// datapath: square, error, radix-2 restoring divider, estimate update and output registers
module nsr_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nsr_pkg::cmd_t                  cmd,
	output nsr_pkg::status_t               status,
	input  logic                           cfg_we,
	input  logic [nsr_pkg::DATA_W-1:0]     cfg_data,
	input  logic [nsr_pkg::DATA_W-1:0]     value,
	output logic [nsr_pkg::DATA_W-1:0]     root,
	output logic [nsr_pkg::OUT_ITER_W-1:0] iterations,
	output logic                           converged
);
	import nsr_pkg::*;

	logic [DATA_W-1:0]    tolerance_q;
	logic [WIDE_W-1:0]    v_wide_q;
	logic [DATA_W-1:0]    x_q;
	logic [ITER_W-1:0]    iter_q;
	logic [WIDE_W-1:0]    sq_q;
	logic [WIDE_W-1:0]    err_q;
	logic                 over_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DATA_W-1:0]    lo_q;
	logic [DATA_W-1:0]    quo_q;
	logic                 big_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    root_q;
	logic [ITER_W-1:0]    iter_out_q;
	logic                 conv_q;

	logic [DATA_W-1:0] one;
	logic [DATA_W-1:0] x_init;
	logic [WIDE_W-1:0] tol_wide;
	logic              sq_ge;
	logic [DVS_W-1:0]  dvs;
	logic [DATA_W-1:0] err_hi;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    trial_sub;
	logic              fits;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] x_next;

	assign one      = DATA_W'(1) << FRAC_BITS;
	assign x_init   = (value > one) ? value : one;
	assign tol_wide = WIDE_W'(tolerance_q) << FRAC_BITS;
	assign sq_ge    = sq_q >= v_wide_q;
	assign dvs      = {x_q, 1'b0};
	assign err_hi   = err_q[WIDE_W-1:DATA_W];
	assign trial    = {rem_q, lo_q[DATA_W-1]};
	assign trial_sub = trial - {1'b0, dvs};
	assign fits     = trial >= {1'b0, dvs};
	assign sum      = {1'b0, x_q} + {1'b0, quo_q};

	always_comb begin
		if (over_q) begin
			if (big_q || (quo_q >= x_q)) begin
				x_next = '0;
			end else begin
				x_next = x_q - quo_q;
			end
		end else begin
			if (big_q || sum[DATA_W]) begin
				x_next = '1;
			end else begin
				x_next = sum[DATA_W-1:0];
			end
		end
	end

	assign status.conv_hit = err_q <= tol_wide;
	assign status.stop     = (iter_q >= ITER_W'(MAX_ITER)) || (x_q == '0);
	assign status.div_last = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (cfg_we) begin
			tolerance_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_wide_q <= WIDE_W'(value) << FRAC_BITS;
			x_q      <= x_init;
			iter_q   <= '0;
		end
		if (cmd.square) begin
			sq_q <= WIDE_W'(x_q) * WIDE_W'(x_q);
		end
		if (cmd.gap) begin
			over_q <= sq_ge;
			err_q  <= sq_ge ? (sq_q - v_wide_q) : (v_wide_q - sq_q);
		end
		// high word at or above the divisor means the quotient does not fit
		if (cmd.div_init) begin
			big_q <= {1'b0, err_hi} >= dvs;
			rem_q <= {1'b0, err_hi};
			lo_q  <= err_q[DATA_W-1:0];
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
			lo_q  <= {lo_q[DATA_W-2:0], 1'b0};
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
		if (cmd.update) begin
			x_q    <= x_next;
			iter_q <= iter_q + ITER_W'(1);
		end
		if (cmd.emit) begin
			root_q     <= x_q;
			iter_out_q <= iter_q;
			conv_q     <= status.conv_hit;
		end
	end

	assign root       = root_q;
	assign iterations = OUT_ITER_W'(iter_out_q);
	assign converged  = conv_q;

endmodule

FILE: design/newton_square_root.sv
// top level of the newton-raphson square root, q16.16 fixed point
// an input beat leads to an output beat after n estimate updates, n = 0..32
// each update runs the 32-step radix-2 divider, which is shared across updates
// throughput: one item at a time; the next input beat is taken once the result is registered
// reset: asynchronous, active low; clears the sequencer and output valid, tolerance to 6554
module newton_square_root (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [nsr_pkg::S_TDATA_W-1:0] s_tdata,  // value[31:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [nsr_pkg::M_TDATA_W-1:0] m_tdata,  // root[31:0], iterations[37:32], zero pad
	output logic [0:0]                    m_tuser,  // converged[0]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nsr_pkg::DATA_W-1:0]    cfg_data
);
	import nsr_pkg::*;

	cmd_t                  cmd;
	status_t               status;
	logic [DATA_W-1:0]     root;
	logic [OUT_ITER_W-1:0] iterations;
	logic                  converged;

	assign cfg_ready = 1'b1;

	nsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	nsr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.value      (s_tdata[DATA_W-1:0]),
		.root       (root),
		.iterations (iterations),
		.converged  (converged)
	);

	assign m_tdata = M_TDATA_W'({iterations, root});
	assign m_tuser = converged;

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input beat taken while an item is in work");

	a_stop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |->
		((m_tdata[DATA_W+OUT_ITER_W-1:DATA_W] == OUT_ITER_W'(MAX_ITER)) ||
		 (m_tdata[DATA_W-1:0] == '0)))
		else $error("unconverged result without cap or zero estimate");

	a_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[DATA_W+OUT_ITER_W-1:DATA_W] <= OUT_ITER_W'(MAX_ITER)))
		else $error("iteration count beyond cap");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.emit)
		else $error("result overwritten while output beat pending");
`endif

endmodule
